// File: design/pvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvs_pkg
// Types and constants shared by the perspective vertex to screen block.
// ----------------------------------------------------------------------------
package pvs_pkg;

   localparam int COORD_BITS   = 32;
   localparam int DEN_BITS     = 32;
   localparam int QUO_BITS     = 63;
   localparam int SIZE_BITS    = 13;
   localparam int PIXEL_BITS   = 16;
   localparam int CSR_BITS     = 2;
   localparam int T_LIMIT_LOG2 = 41;
   localparam int T_BITS       = T_LIMIT_LOG2 + 2;

   localparam logic signed [COORD_BITS-1:0] SCALE_RESET  = 32'sd65536;
   localparam logic [SIZE_BITS-1:0]         WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_BITS-1:0]         HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_X_SCALE       = 2'd0,
      CSR_Y_SCALE       = 2'd1,
      CSR_SCREEN_WIDTH  = 2'd2,
      CSR_SCREEN_HEIGHT = 2'd3
   } csr_index_type;

   // one step of the long division as it moves down the row of cells
   typedef struct packed {
      logic [DEN_BITS-1:0] rem;
      logic [QUO_BITS-1:0] num;
      logic [QUO_BITS-1:0] quo;
      logic [DEN_BITS-1:0] den;
      logic                neg;
   } div_word_type;

endpackage
`default_nettype wire

// File: design/pvs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvs_req_if / pvs_rsp_if
// Valid/ready channels carrying vertex words in and pixel words out.
// ----------------------------------------------------------------------------
interface pvs_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pvs_pkg::COORD_BITS-1:0]    vert_x;
   logic signed [pvs_pkg::COORD_BITS-1:0]    vert_y;
   logic signed [pvs_pkg::COORD_BITS-1:0]    vert_z;
   modport source (output valid, vert_x, vert_y, vert_z, input ready);
   modport sink (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface pvs_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pvs_pkg::PIXEL_BITS-1:0]    pixel_x;
   logic signed [pvs_pkg::PIXEL_BITS-1:0]    pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface
`default_nettype wire

// File: design/pvs_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvs_div_cell
// One restoring-division cell: brings down one dividend bit, makes one
// quotient bit and registers the word for the next cell.
// ----------------------------------------------------------------------------
module pvs_div_cell (
   input  wire                   clock,
   input  wire                   enable,
   input  pvs_pkg::div_word_type word_in,
   output pvs_pkg::div_word_type word_out
);

   pvs_pkg::div_word_type    word_ff;
   pvs_pkg::div_word_type    step_in;
   logic [pvs_pkg::DEN_BITS:0] trial;
   logic [pvs_pkg::DEN_BITS:0] diff;
   logic                       take;

   always_comb begin
      trial = {word_in.rem, word_in.num[pvs_pkg::QUO_BITS-1]};
      diff  = trial - {1'b0, word_in.den};
      take  = ~diff[pvs_pkg::DEN_BITS];
      step_in     = word_in;
      step_in.rem = take ? diff[pvs_pkg::DEN_BITS-1:0]
                         : trial[pvs_pkg::DEN_BITS-1:0];
      step_in.num = {word_in.num[pvs_pkg::QUO_BITS-2:0], 1'b0};
      step_in.quo = {word_in.quo[pvs_pkg::QUO_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= step_in;
      end
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

// File: design/perspective_vertex_to_screen_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_vertex_to_screen_top
// Projects camera-space vertices to screen pixels.
//
// req carries one vertex word (vert_x, vert_y, vert_z, signed fixed point);
// rsp returns one pixel word (pixel_x, pixel_y) for each vertex, in order.
// csr_we/csr_index/csr_wdata write x_scale, y_scale, screen_width and
// screen_height; write them only while no vertex is in flight.
// One vertex is taken every cycle while req.ready is high. The products
// load at the accepting edge, then come the magnitude registers, 63
// division cells (one quotient bit each), the offset/clamp and viewport
// scaling registers, and the output register.
// The whole pipeline shifts together. When rsp stalls, one more word lands
// in a skid register and req.ready drops until the skid register drains.
// Reset (synchronous) empties the pipeline and restores the register
// defaults: scales 1.0, screen 640 by 480.
// ----------------------------------------------------------------------------
module perspective_vertex_to_screen_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   pvs_req_if.sink                            req,
   pvs_rsp_if.source                          rsp,
   input  wire                                csr_we,
   input  wire [pvs_pkg::CSR_BITS-1:0]        csr_index,
   input  wire [pvs_pkg::COORD_BITS-1:0]      csr_wdata
);

   localparam int QB = pvs_pkg::QUO_BITS;
   localparam int TB = pvs_pkg::T_BITS;
   localparam int MB = TB + pvs_pkg::SIZE_BITS + 1;
   localparam int LANES = 2;
   localparam logic signed [64:0] T_MAX = 65'sd1 <<< pvs_pkg::T_LIMIT_LOG2;
   localparam logic signed [64:0] T_MIN = -T_MAX;
   localparam logic signed [64:0] ONE   = 65'sd1 <<< FRAC_BITS;
   localparam logic signed [MB-1:0] BIAS = (MB'(1) <<< (FRAC_BITS + 1)) - MB'(1);
   localparam logic [pvs_pkg::DEN_BITS-1:0] Z_ZERO_DEN =
      pvs_pkg::DEN_BITS'(1) << FRAC_BITS;

   function automatic logic signed [15:0] sat16(input logic signed [MB:0] v);
      if (v > (MB+1)'(32767)) begin
         return 16'sh7fff;
      end else if (v < -(MB+1)'(32768)) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // configuration registers
   logic signed [31:0]                 x_scale_ff;
   logic signed [31:0]                 y_scale_ff;
   logic [pvs_pkg::SIZE_BITS-1:0]      width_ff;
   logic [pvs_pkg::SIZE_BITS-1:0]      height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= pvs_pkg::SCALE_RESET;
         y_scale_ff <= pvs_pkg::SCALE_RESET;
         width_ff   <= pvs_pkg::WIDTH_RESET;
         height_ff  <= pvs_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (pvs_pkg::csr_index_type'(csr_index))
            pvs_pkg::CSR_X_SCALE:       x_scale_ff <= $signed(csr_wdata);
            pvs_pkg::CSR_Y_SCALE:       y_scale_ff <= $signed(csr_wdata);
            pvs_pkg::CSR_SCREEN_WIDTH:  width_ff   <= csr_wdata[pvs_pkg::SIZE_BITS-1:0];
            pvs_pkg::CSR_SCREEN_HEIGHT: height_ff  <= csr_wdata[pvs_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic advance;
   logic out_valid_ff;
   logic skid_valid_ff;
   logic signed [15:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;

   assign advance   = ~skid_valid_ff;
   assign req.ready = advance;

   // valid bits
   logic          v0_ff, v1_ff, va_ff, vb_ff;
   logic [QB-1:0] cell_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         cell_valid_ff <= '0;
         va_ff         <= 1'b0;
         vb_ff         <= 1'b0;
      end else if (advance) begin
         v0_ff         <= req.valid;
         v1_ff         <= v0_ff;
         cell_valid_ff <= {cell_valid_ff[QB-2:0], v1_ff};
         va_ff         <= cell_valid_ff[QB-1];
         vb_ff         <= va_ff;
      end
   end

   // products and divisor
   logic signed [63:0]             prod_ff [LANES];
   logic [pvs_pkg::DEN_BITS-1:0]   den0_ff, den1_ff;
   logic                           zneg0_ff;
   logic [QB-1:0]                  mag_ff [LANES];
   logic                           neg_ff [LANES];
   logic [63:0]                    prod_abs [LANES];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff[0] <= req.vert_x * x_scale_ff;
         prod_ff[1] <= req.vert_y * y_scale_ff;
         den0_ff    <= (req.vert_z == '0) ? Z_ZERO_DEN
                     : (req.vert_z[31] ? 32'(-req.vert_z) : 32'(req.vert_z));
         zneg0_ff   <= req.vert_z[31];
         den1_ff    <= den0_ff;
         for (int l = 0; l < LANES; l++) begin
            mag_ff[l] <= prod_abs[l][QB-1:0];
            neg_ff[l] <= prod_ff[l][63] ^ zneg0_ff;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod_abs[l] = prod_ff[l][63] ? 64'(-prod_ff[l]) : 64'(prod_ff[l]);
      end
   end

   // division cells
   pvs_pkg::div_word_type chain [LANES][QB+1];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_comb begin
         chain[l][0].rem = '0;
         chain[l][0].num = mag_ff[l];
         chain[l][0].quo = '0;
         chain[l][0].den = den1_ff;
         chain[l][0].neg = neg_ff[l];
      end
      for (genvar k = 0; k < QB; k++) begin : g_cell
         pvs_div_cell u_cell (
            .clock    (clock),
            .enable   (advance),
            .word_in  (chain[l][k]),
            .word_out (chain[l][k+1])
         );
      end
   end

   // offset, clamp and viewport scaling
   logic signed [64:0]    t_full [LANES];
   logic signed [TB-1:0]  t_ff   [LANES];
   logic signed [MB-1:0]  m_ff   [LANES];
   logic signed [MB-1:0]  q_div  [LANES];
   logic [pvs_pkg::SIZE_BITS-1:0] size_sel [LANES];

   assign size_sel[0] = width_ff;
   assign size_sel[1] = height_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         t_full[l] = (chain[l][QB].neg ? -$signed({2'b00, chain[l][QB].quo})
                                        :  $signed({2'b00, chain[l][QB].quo})) + ONE;
         q_div[l]  = (m_ff[l] + (m_ff[l][MB-1] ? BIAS : $signed(MB'(0))))
                     >>> (FRAC_BITS + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            if (t_full[l] > T_MAX) begin
               t_ff[l] <= T_MAX[TB-1:0];
            end else if (t_full[l] < T_MIN) begin
               t_ff[l] <= T_MIN[TB-1:0];
            end else begin
               t_ff[l] <= t_full[l][TB-1:0];
            end
            m_ff[l] <= t_ff[l] * $signed({1'b0, size_sel[l]});
         end
      end
   end

   logic signed [15:0] pipe_x, pipe_y;
   assign pipe_x = sat16({q_div[0][MB-1], q_div[0]});
   assign pipe_y = sat16($signed({{(MB+1-pvs_pkg::SIZE_BITS){1'b0}}, height_ff})
                         - $signed({q_div[1][MB-1], q_div[1]}));

   // output register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp.ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (~out_valid_ff || rsp.ready) begin
         out_valid_ff <= vb_ff;
      end else if (vb_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp.ready) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
         end
      end else if (~out_valid_ff || rsp.ready) begin
         out_x_ff <= pipe_x;
         out_y_ff <= pipe_y;
      end else begin
         skid_x_ff <= pipe_x;
         skid_y_ff <= pipe_y;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.pixel_x = out_x_ff;
   assign rsp.pixel_y = out_y_ff;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp.ready) |=> skid_valid_ff)
      else $error("skid word lost under stall");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req.ready)
      else $error("word accepted while skid full");

   a_stall_keeps_pipe: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(cell_valid_ff) || $past(rsp.ready))
      else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
